[rtl/core/rgbcc_pkg.sv]
// Package with constants, types and helper functions for the RGB565 colour class counter.
package rgbcc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int POS_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int GEOM_W = 11;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 21;
    localparam int OUT_W  = 16;
    localparam int CONF_W = 7;
    localparam int DIV_W  = 28;
    localparam int IDX_W  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_SKIN   = 3'd1,
        CLS_RED    = 3'd2,
        CLS_GREEN  = 3'd3,
        CLS_BLUE   = 3'd4,
        CLS_CUSTOM = 3'd5
    } t_class;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_SAMPLE_STEP  = 3'd2,
        REG_TARGET_RED   = 3'd3,
        REG_TARGET_GREEN = 3'd4,
        REG_TARGET_BLUE  = 3'd5,
        REG_TARGET_TOL   = 3'd6
    } t_reg_index;

    // Saturating increment of a frame counter.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic en);
        bump = (en && (c != CNT_MAX)) ? c + 1'b1 : c;
    endfunction

    // Clamp a counter to the 16-bit result range.
    function automatic logic [OUT_W-1:0] sat16(input logic [CNT_W-1:0] c);
        sat16 = (c[CNT_W-1:OUT_W] != '0) ? {OUT_W{1'b1}} : c[OUT_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] absdiff(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

endpackage

[rtl/core/rgb565_colour_class_counter_unit.sv]
// Top level of the RGB565 colour class counter with its frame-end sequencer.
//
// Flow: an ordinary pixel transaction passes through accept and then count, and no new
// pixel is taken until the count is done. For the last pixel of a frame the result is
// registered after 4 passes of the shared 28-bit subtract/compare unit for the dominant-class
// search, 1 multiply by 100 and, unless no class was seen, 7 restoring-division steps on the
// same unit. FIN waits while the previous result still waits for the receiver. Reset
// (synchronous, active low) restores the default 320 x 240 geometry, step 1, a black custom
// target with zero tolerance, and clears all positions and counters and the output valid flag.
module rgb565_colour_class_counter_unit
    import rgbcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [GEOM_W-1:0]    i_cfg_data,
    // Pixel input channel.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_pixel_word,
    // Frame result channel.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [OUT_W-1:0]     o_samples_taken,
    output logic [OUT_W-1:0]     o_skin_total,
    output logic [OUT_W-1:0]     o_red_total,
    output logic [OUT_W-1:0]     o_green_total,
    output logic [OUT_W-1:0]     o_blue_total,
    output logic [OUT_W-1:0]     o_custom_total,
    output logic [2:0]           o_dominant_class,
    output logic [CONF_W-1:0]    o_confidence_pct
);

    // The sequencer. Each pixel passes through IDLE (accept) and PIXEL (count). The last pixel
    // of a frame continues through the class search, the multiply, the divider (skipped when
    // no class was seen) and FIN, where the result enters the output register once it is free.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PIXEL = 6'b000010,
        ST_MAXS  = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [GEOM_W-1:0] r_frame_width;
    logic [GEOM_W-1:0] r_frame_height;
    logic [BYTE_W-1:0] r_sample_step;
    logic [BYTE_W-1:0] r_target_red;
    logic [BYTE_W-1:0] r_target_green;
    logic [BYTE_W-1:0] r_target_blue;
    logic [BYTE_W-1:0] r_target_tol;

    // Raster position and subsampling phase of the next pixel.
    logic [POS_W-1:0]  r_col_pos;
    logic [ROW_W-1:0]  r_row_pos;
    logic [BYTE_W-1:0] r_col_phase;
    logic [BYTE_W-1:0] r_row_phase;

    // The accepted pixel and what the position logic decided about it.
    logic [15:0]       r_pixel;
    logic              r_sampled;
    logic              r_frame_end;

    // Frame counters.
    logic [CNT_W-1:0]  r_samp_cnt;
    logic [CNT_W-1:0]  r_skin_cnt;
    logic [CNT_W-1:0]  r_red_cnt;
    logic [CNT_W-1:0]  r_green_cnt;
    logic [CNT_W-1:0]  r_blue_cnt;
    logic [CNT_W-1:0]  r_custom_cnt;
    logic [CNT_W-1:0]  n_samp_cnt;
    logic [CNT_W-1:0]  n_skin_cnt;
    logic [CNT_W-1:0]  n_red_cnt;
    logic [CNT_W-1:0]  n_green_cnt;
    logic [CNT_W-1:0]  n_blue_cnt;
    logic [CNT_W-1:0]  n_custom_cnt;

    // Frame-end working registers: running maximum, its class, search index, remainder,
    // quotient and division step.
    logic [CNT_W-1:0]  r_best;
    t_class            r_cls;
    logic [1:0]        r_idx;
    logic [DIV_W-1:0]  r_rem;
    logic [CONF_W-1:0] r_quot;
    logic [2:0]        r_step;

    // Output register.
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_samp;
    logic [OUT_W-1:0]  r_out_skin;
    logic [OUT_W-1:0]  r_out_red;
    logic [OUT_W-1:0]  r_out_green;
    logic [OUT_W-1:0]  r_out_blue;
    logic [OUT_W-1:0]  r_out_custom;
    t_class            r_out_cls;
    logic [CONF_W-1:0] r_out_conf;

    // Effective geometry after clamping the raw register values.
    logic [GEOM_W-1:0] eff_width;
    logic [GEOM_W-1:0] eff_height;
    logic [BYTE_W-1:0] eff_step;
    logic              row_end;
    logic              frame_end;
    logic              pix_sampled;
    logic [BYTE_W:0]   col_phase_inc;
    logic [BYTE_W:0]   row_phase_inc;

    // Pixel widening and classification.
    logic [4:0]        r5;
    logic [5:0]        g6;
    logic [4:0]        b5;
    logic [BYTE_W-1:0] red8;
    logic [BYTE_W-1:0] green8;
    logic [BYTE_W-1:0] blue8;
    logic [BYTE_W:0]   rx;
    logic [BYTE_W:0]   gx;
    logic [BYTE_W:0]   bx;
    logic              is_skin;
    logic              is_red;
    logic              is_green;
    logic              is_blue;
    logic              is_custom;

    // Shared subtract/compare unit.
    logic [DIV_W-1:0]  alu_a;
    logic [DIV_W-1:0]  alu_b;
    logic [DIV_W:0]    alu_diff;
    logic              alu_lt;
    logic [CNT_W-1:0]  cand_cnt;
    t_class            cand_cls;

    logic              in_fire;

    assign in_fire     = i_valid && o_ready;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Geometry clamps: a zero width, height or step counts as one, and a size beyond the
    // largest supported frame is held at that maximum.
    always_comb begin
        if (r_frame_width == '0) begin
            eff_width = GEOM_W'(1);
        end else if (r_frame_width > GEOM_W'(MAX_WIDTH)) begin
            eff_width = GEOM_W'(MAX_WIDTH);
        end else begin
            eff_width = r_frame_width;
        end
        if (r_frame_height == '0) begin
            eff_height = GEOM_W'(1);
        end else if (r_frame_height > GEOM_W'(MAX_HEIGHT)) begin
            eff_height = GEOM_W'(MAX_HEIGHT);
        end else begin
            eff_height = r_frame_height;
        end
        eff_step = (r_sample_step == '0) ? BYTE_W'(1) : r_sample_step;
    end

    // A row ends when the column reaches or passes the last column of the current width, which
    // keeps the raster wrapping even if the geometry was shrunk in the middle of a frame.
    assign row_end       = (GEOM_W'(r_col_pos) + GEOM_W'(1)) >= eff_width;
    assign frame_end     = row_end && ((GEOM_W'(r_row_pos) + GEOM_W'(1)) >= eff_height);
    assign pix_sampled   = (r_col_phase == '0) && (r_row_phase == '0);
    assign col_phase_inc = {1'b0, r_col_phase} + 1'b1;
    assign row_phase_inc = {1'b0, r_row_phase} + 1'b1;

    // Widen RGB565 to 8 bits per channel by replicating the top bits into the low bits.
    assign r5     = r_pixel[15:11];
    assign g6     = r_pixel[10:5];
    assign b5     = r_pixel[4:0];
    assign red8   = {r5, r5[4:2]};
    assign green8 = {g6, g6[5:4]};
    assign blue8  = {b5, b5[4:2]};
    assign rx     = {1'b0, red8};
    assign gx     = {1'b0, green8};
    assign bx     = {1'b0, blue8};

    // Classes in priority order; the sums are nine bits wide so that no threshold wraps.
    assign is_skin  = (rx > 9'd95) && (gx > 9'd40) && (bx > 9'd20) && (rx > gx + 9'd15)
                   && (rx > bx + 9'd15) && (rx > 9'd60);
    assign is_red   = (rx > 9'd140) && (rx > gx + 9'd40) && (rx > bx + 9'd40);
    assign is_green = (gx > 9'd100) && (gx > rx + 9'd30) && (gx > bx + 9'd30);
    assign is_blue  = (bx > 9'd90) && (bx > rx + 9'd25) && (bx > gx + 9'd25);

    // The custom match is independent of the priority classes.
    assign is_custom = (absdiff(red8, r_target_red) <= r_target_tol)
                    && (absdiff(green8, r_target_green) <= r_target_tol)
                    && (absdiff(blue8, r_target_blue) <= r_target_tol);

    always_comb begin
        n_samp_cnt   = bump(r_samp_cnt, r_sampled);
        n_skin_cnt   = bump(r_skin_cnt, r_sampled && is_skin);
        n_red_cnt    = bump(r_red_cnt, r_sampled && !is_skin && is_red);
        n_green_cnt  = bump(r_green_cnt, r_sampled && !is_skin && !is_red && is_green);
        n_blue_cnt   = bump(r_blue_cnt,
                            r_sampled && !is_skin && !is_red && !is_green && is_blue);
        n_custom_cnt = bump(r_custom_cnt, r_sampled && is_custom);
    end

    // Candidate for the dominant-class search, visited in class order after skin.
    always_comb begin
        case (r_idx)
            2'd0: begin
                cand_cnt = r_red_cnt;
                cand_cls = CLS_RED;
            end
            2'd1: begin
                cand_cnt = r_green_cnt;
                cand_cls = CLS_GREEN;
            end
            2'd2: begin
                cand_cnt = r_blue_cnt;
                cand_cls = CLS_BLUE;
            end
            default: begin
                cand_cnt = r_custom_cnt;
                cand_cls = CLS_CUSTOM;
            end
        endcase
    end

    // The one subtractor. In the search it tests whether the running maximum is below the
    // candidate (strictly greater wins, so ties keep the earlier class). In the divider it
    // subtracts the sample count shifted to the current quotient bit from the remainder.
    always_comb begin
        if (r_state == ST_DIV) begin
            alu_a = r_rem;
            alu_b = DIV_W'({{(DIV_W-CNT_W){1'b0}}, r_samp_cnt} << r_step);
        end else begin
            alu_a = DIV_W'(r_best);
            alu_b = DIV_W'(cand_cnt);
        end
        alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
        alu_lt   = alu_diff[DIV_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_frame_width  <= GEOM_W'(320);
            r_frame_height <= GEOM_W'(240);
            r_sample_step  <= BYTE_W'(1);
            r_target_red   <= '0;
            r_target_green <= '0;
            r_target_blue  <= '0;
            r_target_tol   <= '0;
            r_col_pos      <= '0;
            r_row_pos      <= '0;
            r_col_phase    <= '0;
            r_row_phase    <= '0;
            r_sampled      <= 1'b0;
            r_frame_end    <= 1'b0;
            r_samp_cnt     <= '0;
            r_skin_cnt     <= '0;
            r_red_cnt      <= '0;
            r_green_cnt    <= '0;
            r_blue_cnt     <= '0;
            r_custom_cnt   <= '0;
            r_idx          <= '0;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
            r_out_cls      <= CLS_NONE;
            r_out_conf     <= '0;
        end else begin
            // Configuration transactions; an index beyond the register list is ignored.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    REG_SAMPLE_STEP:  r_sample_step  <= i_cfg_data[BYTE_W-1:0];
                    REG_TARGET_RED:   r_target_red   <= i_cfg_data[BYTE_W-1:0];
                    REG_TARGET_GREEN: r_target_green <= i_cfg_data[BYTE_W-1:0];
                    REG_TARGET_BLUE:  r_target_blue  <= i_cfg_data[BYTE_W-1:0];
                    REG_TARGET_TOL:   r_target_tol   <= i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end

            // In FIN the valid flag is handled there, since a new result may replace the
            // one that leaves in the same cycle.
            if (r_out_valid && i_ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_pixel     <= i_pixel_word;
                        r_sampled   <= pix_sampled;
                        r_frame_end <= frame_end;
                        // Advance the raster; the frame end itself wraps to the origin.
                        if (frame_end) begin
                            r_col_pos   <= '0;
                            r_row_pos   <= '0;
                            r_col_phase <= '0;
                            r_row_phase <= '0;
                        end else if (row_end) begin
                            r_col_pos   <= '0;
                            r_col_phase <= '0;
                            r_row_pos   <= r_row_pos + 1'b1;
                            r_row_phase <= (row_phase_inc >= {1'b0, eff_step}) ? '0
                                         : row_phase_inc[BYTE_W-1:0];
                        end else begin
                            r_col_pos   <= r_col_pos + 1'b1;
                            r_col_phase <= (col_phase_inc >= {1'b0, eff_step}) ? '0
                                         : col_phase_inc[BYTE_W-1:0];
                        end
                        r_state <= ST_PIXEL;
                    end
                end
                ST_PIXEL: begin
                    r_samp_cnt   <= n_samp_cnt;
                    r_skin_cnt   <= n_skin_cnt;
                    r_red_cnt    <= n_red_cnt;
                    r_green_cnt  <= n_green_cnt;
                    r_blue_cnt   <= n_blue_cnt;
                    r_custom_cnt <= n_custom_cnt;
                    if (r_frame_end) begin
                        r_best  <= n_skin_cnt;
                        r_cls   <= CLS_SKIN;
                        r_idx   <= '0;
                        r_state <= ST_MAXS;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_MAXS: begin
                    if (alu_lt) begin
                        r_best <= cand_cnt;
                        r_cls  <= cand_cls;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == 2'd3) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_quot <= '0;
                    r_step <= 3'(CONF_W - 1);
                    if (r_best == '0) begin
                        // No class was seen at all: no dominant class, zero confidence.
                        r_cls   <= CLS_NONE;
                        r_state <= ST_FIN;
                    end else begin
                        r_rem   <= DIV_W'({{(DIV_W-CNT_W){1'b0}}, r_best} * DIV_W'(100));
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // The best count never exceeds the sample count, so the quotient fits
                    // in seven bits and seven restoring steps suffice.
                    if (!alu_lt) begin
                        r_rem          <= alu_diff[DIV_W-1:0];
                        r_quot[r_step] <= 1'b1;
                    end
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_samp   <= sat16(r_samp_cnt);
                        r_out_skin   <= sat16(r_skin_cnt);
                        r_out_red    <= sat16(r_red_cnt);
                        r_out_green  <= sat16(r_green_cnt);
                        r_out_blue   <= sat16(r_blue_cnt);
                        r_out_custom <= sat16(r_custom_cnt);
                        r_out_cls    <= r_cls;
                        r_out_conf   <= (r_cls == CLS_NONE) ? '0 : r_quot;
                        r_samp_cnt   <= '0;
                        r_skin_cnt   <= '0;
                        r_red_cnt    <= '0;
                        r_green_cnt  <= '0;
                        r_blue_cnt   <= '0;
                        r_custom_cnt <= '0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_samples_taken  = r_out_samp;
    assign o_skin_total     = r_out_skin;
    assign o_red_total      = r_out_red;
    assign o_green_total    = r_out_green;
    assign o_blue_total     = r_out_blue;
    assign o_custom_total   = r_out_custom;
    assign o_dominant_class = r_out_cls;
    assign o_confidence_pct = r_out_conf;

    // An accepted pixel is always counted in the following cycle.
    a_accept_then_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_PIXEL))
        else $error("accepted pixel not followed by count cycle");

    // The priority classes are exclusive, so together they never pass the sample count.
    a_class_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (23'(r_skin_cnt) + 23'(r_red_cnt) + 23'(r_green_cnt) + 23'(r_blue_cnt))
            <= 23'(r_samp_cnt))
        else $error("class counts exceed sample count");

    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_conf <= CONF_W'(100)))
        else $error("confidence above 100");

    a_none_zero_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_cls == CLS_NONE)) |-> (r_out_conf == '0))
        else $error("nonzero confidence without a dominant class");

endmodule

[bench/rgbcc_checker.sv]
// Checker that predicts the frame summaries of the colour class counter and compares them.
module rgbcc_checker
    import rgbcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [GEOM_W-1:0] i_cfg_data,
    input  logic              i_pix_valid,
    input  logic              i_pix_ready,
    input  logic [15:0]       i_pixel_word,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [OUT_W-1:0]  i_samples_taken,
    input  logic [OUT_W-1:0]  i_skin_total,
    input  logic [OUT_W-1:0]  i_red_total,
    input  logic [OUT_W-1:0]  i_green_total,
    input  logic [OUT_W-1:0]  i_blue_total,
    input  logic [OUT_W-1:0]  i_custom_total,
    input  logic [2:0]        i_dominant_class,
    input  logic [CONF_W-1:0] i_confidence_pct,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct {
        logic [OUT_W-1:0]  samples;
        logic [OUT_W-1:0]  skin;
        logic [OUT_W-1:0]  red;
        logic [OUT_W-1:0]  green;
        logic [OUT_W-1:0]  blue;
        logic [OUT_W-1:0]  custom;
        t_class            dominant;
        logic [CONF_W-1:0] confidence;
    } t_frame_summary;

    t_frame_summary pending_summaries[$];

    logic [GEOM_W-1:0] width_reg;
    logic [GEOM_W-1:0] height_reg;
    logic [BYTE_W-1:0] step_reg;
    logic [BYTE_W-1:0] target_r;
    logic [BYTE_W-1:0] target_g;
    logic [BYTE_W-1:0] target_b;
    logic [BYTE_W-1:0] tolerance_reg;

    logic [POS_W-1:0]  col_pos;
    logic [ROW_W-1:0]  row_pos;
    logic [BYTE_W-1:0] col_phase;
    logic [BYTE_W-1:0] row_phase;
    logic [CNT_W-1:0]  sample_cnt;
    logic [CNT_W-1:0]  skin_cnt;
    logic [CNT_W-1:0]  red_cnt;
    logic [CNT_W-1:0]  green_cnt;
    logic [CNT_W-1:0]  blue_cnt;
    logic [CNT_W-1:0]  custom_cnt;

    int fails = 0;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] clamp16(input logic [CNT_W-1:0] c);
        return (c > {OUT_W{1'b1}}) ? {OUT_W{1'b1}} : c[OUT_W-1:0];
    endfunction

    function automatic int distance(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic clear_frame_state();
        col_pos    = '0;
        row_pos    = '0;
        col_phase  = '0;
        row_phase  = '0;
        sample_cnt = '0;
        skin_cnt   = '0;
        red_cnt    = '0;
        green_cnt  = '0;
        blue_cnt   = '0;
        custom_cnt = '0;
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [GEOM_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:  width_reg     = data;
            REG_FRAME_HEIGHT: height_reg    = data;
            REG_SAMPLE_STEP:  step_reg      = data[BYTE_W-1:0];
            REG_TARGET_RED:   target_r      = data[BYTE_W-1:0];
            REG_TARGET_GREEN: target_g      = data[BYTE_W-1:0];
            REG_TARGET_BLUE:  target_b      = data[BYTE_W-1:0];
            REG_TARGET_TOL:   tolerance_reg = data[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    // Widen the pixel by bit replication, then count it in at most one class and maybe as custom.
    task automatic count_pixel(input logic [15:0] pix);
        int r;
        int g;
        int b;
        r = {pix[15:11], pix[15:13]};
        g = {pix[10:5], pix[10:9]};
        b = {pix[4:0], pix[4:2]};
        sample_cnt = sat_inc(sample_cnt);
        if (r > 95 && g > 40 && b > 20 && r > g && r > b &&
            r - g > 15 && r - b > 15 && r > 60) begin
            skin_cnt = sat_inc(skin_cnt);
        end else if (r > 140 && r > g + 40 && r > b + 40) begin
            red_cnt = sat_inc(red_cnt);
        end else if (g > 100 && g > r + 30 && g > b + 30) begin
            green_cnt = sat_inc(green_cnt);
        end else if (b > 90 && b > r + 25 && b > g + 25) begin
            blue_cnt = sat_inc(blue_cnt);
        end
        if (distance(r, target_r) <= tolerance_reg &&
            distance(g, target_g) <= tolerance_reg &&
            distance(b, target_b) <= tolerance_reg) begin
            custom_cnt = sat_inc(custom_cnt);
        end
    endtask

    task automatic step_raster(input logic [15:0] pix);
        int eff_w;
        int eff_h;
        int eff_step;
        logic row_end;
        logic frame_end;
        logic [CNT_W-1:0] best;
        t_class cls;
        t_frame_summary s;
        eff_w = (width_reg == '0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        eff_h = (height_reg == '0) ? 1 :
                ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
        eff_step = (step_reg == '0) ? 1 : int'(step_reg);

        if (col_phase == '0 && row_phase == '0) count_pixel(pix);

        // Reaching or passing the edge ends a row, so a shrunken geometry still wraps.
        row_end   = (int'(col_pos) + 1 >= eff_w);
        frame_end = row_end && (int'(row_pos) + 1 >= eff_h);

        if (!frame_end) begin
            if (row_end) begin
                col_pos   = '0;
                col_phase = '0;
                row_pos   = row_pos + 1'b1;
                row_phase = (int'(row_phase) + 1 >= eff_step) ? '0 : row_phase + 1'b1;
            end else begin
                col_pos   = col_pos + 1'b1;
                col_phase = (int'(col_phase) + 1 >= eff_step) ? '0 : col_phase + 1'b1;
            end
        end else begin
            // Strict greater-than keeps the earlier class on a tie.
            best = skin_cnt;
            cls  = CLS_SKIN;
            if (red_cnt > best) begin
                best = red_cnt;
                cls  = CLS_RED;
            end
            if (green_cnt > best) begin
                best = green_cnt;
                cls  = CLS_GREEN;
            end
            if (blue_cnt > best) begin
                best = blue_cnt;
                cls  = CLS_BLUE;
            end
            if (custom_cnt > best) begin
                best = custom_cnt;
                cls  = CLS_CUSTOM;
            end
            s.samples = clamp16(sample_cnt);
            s.skin    = clamp16(skin_cnt);
            s.red     = clamp16(red_cnt);
            s.green   = clamp16(green_cnt);
            s.blue    = clamp16(blue_cnt);
            s.custom  = clamp16(custom_cnt);
            if (sample_cnt == '0 || best == '0) begin
                s.dominant   = CLS_NONE;
                s.confidence = '0;
            end else begin
                s.dominant   = cls;
                s.confidence = CONF_W'(((longint'(best) * 100) / longint'(sample_cnt) > 100) ?
                               100 : (longint'(best) * 100) / longint'(sample_cnt));
            end
            pending_summaries.push_back(s);
            clear_frame_state();
        end
    endtask

    task automatic check_field(input string field, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", field, expected, actual);
            fails++;
        end
    endtask

    task automatic compare_summary();
        t_frame_summary s;
        if (pending_summaries.size() == 0) begin
            $error("frame summary transaction with no prediction waiting");
            fails++;
        end else begin
            s = pending_summaries.pop_front();
            check_field("samples_taken", s.samples, i_samples_taken);
            check_field("skin_total", s.skin, i_skin_total);
            check_field("red_total", s.red, i_red_total);
            check_field("green_total", s.green, i_green_total);
            check_field("blue_total", s.blue, i_blue_total);
            check_field("custom_total", s.custom, i_custom_total);
            check_field("dominant_class", int'(s.dominant), i_dominant_class);
            check_field("confidence_pct", s.confidence, i_confidence_pct);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg     = 11'd320;
            height_reg    = 11'd240;
            step_reg      = 8'd1;
            target_r      = '0;
            target_g      = '0;
            target_b      = '0;
            tolerance_reg = '0;
            clear_frame_state();
            pending_summaries.delete();
        end else begin
            // Results are compared before this edge's pixel can add a new prediction.
            if (i_res_valid && i_res_ready) compare_summary();
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_pix_valid && i_pix_ready) step_raster(i_pixel_word);
        end
        o_pending    <= pending_summaries.size();
        o_fail_count <= fails;
    end

endmodule

[bench/testbench.sv]
// Top of the colour class counter bench: clock, reset, stimulus and the final verdict.
module testbench
    import rgbcc_pkg::*;
();

    localparam int     HALF_PERIOD       = 5;
    localparam int     RESET_CYCLES      = 8;
    // Wait after the last summary so that the frame-end sequencer has finished.
    localparam int     SETTLE_CYCLES     = 40;
    localparam int     IDLE_PCT          = 19;
    localparam int     HOLD_CYCLES       = 400;
    localparam int     RANDOM_PIXELS     = 1000;
    localparam int     MIN_RANDOM_FRAMES = 40;
    localparam longint RUN_LIMIT         = 20_000_000;

    // Register index that maps to no register; writes to it must be ignored.
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [15:0] PIX_SKIN  = 16'hCBCA;
    localparam logic [15:0] PIX_RED   = 16'hF800;
    localparam logic [15:0] PIX_GREEN = 16'h07E0;
    localparam logic [15:0] PIX_BLUE  = 16'h001F;
    localparam logic [15:0] PIX_BLACK = 16'h0000;
    localparam logic [15:0] PIX_WHITE = 16'hFFFF;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_valid  = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index  = '0;
    logic [GEOM_W-1:0] i_cfg_data   = '0;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic [15:0]       i_pixel_word = '0;
    logic              o_valid;
    logic              i_ready      = 1'b0;
    logic [OUT_W-1:0]  o_samples_taken;
    logic [OUT_W-1:0]  o_skin_total;
    logic [OUT_W-1:0]  o_red_total;
    logic [OUT_W-1:0]  o_green_total;
    logic [OUT_W-1:0]  o_blue_total;
    logic [OUT_W-1:0]  o_custom_total;
    logic [2:0]        o_dominant_class;
    logic [CONF_W-1:0] o_confidence_pct;

    int fail_count;
    int pending;

    // Stimulus-side copy of what has been written, used to size frames and aim pixels.
    logic [GEOM_W-1:0] cur_w    = 11'd320;
    logic [GEOM_W-1:0] cur_h    = 11'd240;
    logic [BYTE_W-1:0] target_r = '0;
    logic [BYTE_W-1:0] target_g = '0;
    logic [BYTE_W-1:0] target_b = '0;

    // Traffic shaping shared between the sender and the receiver processes.
    logic no_stall     = 1'b0;
    logic hold_off_req = 1'b0;
    logic hold_taken   = 1'b0;
    int   hold_left    = 0;

    int random_pixels = 0;
    int random_frames = 0;

    rgb565_colour_class_counter_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_word     (i_pixel_word),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_samples_taken  (o_samples_taken),
        .o_skin_total     (o_skin_total),
        .o_red_total      (o_red_total),
        .o_green_total    (o_green_total),
        .o_blue_total     (o_blue_total),
        .o_custom_total   (o_custom_total),
        .o_dominant_class (o_dominant_class),
        .o_confidence_pct (o_confidence_pct)
    );

    rgbcc_checker summary_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_pix_valid      (i_valid),
        .i_pix_ready      (o_ready),
        .i_pixel_word     (i_pixel_word),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_samples_taken  (o_samples_taken),
        .i_skin_total     (o_skin_total),
        .i_red_total      (o_red_total),
        .i_green_total    (o_green_total),
        .i_blue_total     (o_blue_total),
        .i_custom_total   (o_custom_total),
        .i_dominant_class (o_dominant_class),
        .i_confidence_pct (o_confidence_pct),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Receiver. Normally it stalls at random; once, on request, it holds off for a long
    // stretch so that the result register fills and the block stops taking pixels.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_off_req && !hold_taken) begin
            i_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            i_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Number of pixel transactions in one frame, with the block's clamping of the geometry.
    function automatic int frame_pixel_count(input logic [GEOM_W-1:0] w,
                                             input logic [GEOM_W-1:0] h);
        int ew;
        int eh;
        ew = (w == '0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : int'(w));
        eh = (h == '0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : int'(h));
        return ew * eh;
    endfunction

    // A target byte with its extremes well represented.
    function automatic logic [BYTE_W-1:0] pick_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return '1;
        return BYTE_W'($urandom);
    endfunction

    // Pixels are aimed at each class region, at the custom target, at the extremes,
    // or are plain noise, so that every branch of the classifier gets exercised.
    function automatic logic [15:0] make_pixel();
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        int pick;
        pick = $urandom_range(99);
        r5 = 5'($urandom);
        g6 = 6'($urandom);
        b5 = 5'($urandom);
        if (pick < 15) begin
            r5 = 5'($urandom_range(31, 14));
            g6 = 6'($urandom_range(45, 10));
            b5 = 5'($urandom_range(18, 3));
        end else if (pick < 30) begin
            r5 = 5'($urandom_range(31, 18));
            g6 = 6'($urandom_range(20, 0));
            b5 = 5'($urandom_range(10, 0));
        end else if (pick < 45) begin
            r5 = 5'($urandom_range(14, 0));
            g6 = 6'($urandom_range(63, 26));
            b5 = 5'($urandom_range(14, 0));
        end else if (pick < 60) begin
            r5 = 5'($urandom_range(10, 0));
            g6 = 6'($urandom_range(22, 0));
            b5 = 5'($urandom_range(31, 12));
        end else if (pick < 75) begin
            // Close to the custom colour, one step either way per channel.
            r5 = target_r[7:3] + 5'($urandom_range(2)) - 5'd1;
            g6 = target_g[7:2] + 6'($urandom_range(2)) - 6'd1;
            b5 = target_b[7:3] + 5'($urandom_range(2)) - 5'd1;
        end else if (pick < 80) begin
            return $urandom_range(1) ? PIX_WHITE : PIX_BLACK;
        end
        return {r5, g6, b5};
    endfunction

    // Sender gaps; none while the no-stall stretch is running.
    task automatic idle_gap();
        while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
            i_valid     <= 1'b0;
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Offer one pixel and return at the edge where the transaction completes. Valid is
    // left high so that a following pixel can be offered without a gap.
    task automatic send_pixel(input logic [15:0] pix);
        idle_gap();
        i_valid      <= 1'b1;
        i_pixel_word <= pix;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GEOM_W-1:0] data);
        idle_gap();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:  cur_w    = data;
            REG_FRAME_HEIGHT: cur_h    = data;
            REG_TARGET_RED:   target_r = data[BYTE_W-1:0];
            REG_TARGET_GREEN: target_g = data[BYTE_W-1:0];
            REG_TARGET_BLUE:  target_b = data[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic release_cfg();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop both valids and wait until every predicted summary has come out, then let the
    // frame-end sequencer drain before anything is reconfigured. The first edge lets the
    // checker's count catch up with a transaction completed at the current edge.
    task automatic wait_for_idle();
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_frame();
        int count;
        count = frame_pixel_count(cur_w, cur_h);
        repeat (count) send_pixel(make_pixel());
        random_pixels += count;
    endtask

    // One random setting followed by a few frames. Most frames are tiny; a few use a
    // width or height near or past the largest, with the other side at one so they stay short.
    task automatic random_phase();
        logic [GEOM_W-1:0] w;
        logic [GEOM_W-1:0] h;
        logic [BYTE_W-1:0] st;
        logic [BYTE_W-1:0] tol;
        int shape;
        int frames;
        shape  = $urandom_range(99);
        frames = $urandom_range(4, 1);
        if (shape < 2) begin
            w      = GEOM_W'($urandom_range(2047, 1000));
            h      = GEOM_W'($urandom_range(1, 0));
            frames = 1;
        end else if (shape < 4) begin
            w      = GEOM_W'($urandom_range(1, 0));
            h      = GEOM_W'($urandom_range(2047, 1000));
            frames = 1;
        end else begin
            w = GEOM_W'($urandom_range(12, 0));
            h = GEOM_W'($urandom_range(9, 0));
        end
        shape = $urandom_range(99);
        if (shape < 40)      st = 8'd1;
        else if (shape < 45) st = 8'd0;
        else if (shape < 50) st = 8'd255;
        else                 st = BYTE_W'($urandom_range(4, 2));
        shape = $urandom_range(99);
        if (shape < 15)      tol = '0;
        else if (shape < 25) tol = '1;
        else if (shape < 80) tol = BYTE_W'($urandom_range(24, 0));
        else                 tol = BYTE_W'($urandom);

        wait_for_idle();
        // The three upper data bits are don't-care for the byte-wide registers.
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_SAMPLE_STEP, {3'($urandom), st});
        if ($urandom_range(99) < 60) write_reg(REG_TARGET_RED, {3'($urandom), pick_byte()});
        if ($urandom_range(99) < 60) write_reg(REG_TARGET_GREEN, {3'($urandom), pick_byte()});
        if ($urandom_range(99) < 60) write_reg(REG_TARGET_BLUE, {3'($urandom), pick_byte()});
        if ($urandom_range(99) < 60) write_reg(REG_TARGET_TOL, {3'($urandom), tol});
        if ($urandom_range(99) < 10) write_reg(REG_UNUSED, GEOM_W'($urandom));
        release_cfg();
        repeat (frames) send_frame();
        random_frames += frames;
    endtask

    initial begin
        #RUN_LIMIT;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int phase;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: five pixels into a 320-wide row end nothing. The width then drops
        // to one, so every further pixel closes a row and the default height of 240 ends
        // the frame, all at step 1 with a black target and zero tolerance.
        repeat (5) send_pixel(make_pixel());
        wait_for_idle();
        write_reg(REG_FRAME_WIDTH, 11'd1);
        release_cfg();
        repeat (240) send_pixel(make_pixel());
        wait_for_idle();

        // Single-pixel frames with a white target and zero tolerance: a white pixel is
        // no class but matches the target, and a black one leaves every class empty.
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        write_reg(REG_SAMPLE_STEP, 11'd1);
        write_reg(REG_TARGET_RED, 11'd255);
        write_reg(REG_TARGET_GREEN, 11'd255);
        write_reg(REG_TARGET_BLUE, 11'd255);
        write_reg(REG_TARGET_TOL, 11'd0);
        release_cfg();
        send_pixel(PIX_WHITE);
        send_pixel(PIX_BLACK);
        wait_for_idle();

        // Zero width, height and step all act as one.
        write_reg(REG_FRAME_WIDTH, 11'd0);
        write_reg(REG_FRAME_HEIGHT, 11'd0);
        write_reg(REG_SAMPLE_STEP, 11'd0);
        release_cfg();
        send_pixel(make_pixel());
        wait_for_idle();

        // Every class once or twice, with skin and red tied so the earlier class wins.
        // The unused index is written too and must change nothing; the high data bits
        // on the byte-wide targets must be dropped.
        write_reg(REG_FRAME_WIDTH, 11'd4);
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        write_reg(REG_SAMPLE_STEP, 11'd1);
        write_reg(REG_TARGET_RED, 11'h700);
        write_reg(REG_TARGET_GREEN, 11'h700);
        write_reg(REG_TARGET_BLUE, 11'h700);
        write_reg(REG_TARGET_TOL, 11'h700);
        write_reg(REG_UNUSED, 11'h7FF);
        release_cfg();
        send_pixel(PIX_SKIN);
        send_pixel(PIX_RED);
        send_pixel(PIX_SKIN);
        send_pixel(PIX_RED);
        send_pixel(PIX_GREEN);
        send_pixel(PIX_BLUE);
        send_pixel(PIX_BLACK);
        send_pixel(PIX_WHITE);
        wait_for_idle();

        // Largest step: only the first pixel of the frame is sampled.
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_SAMPLE_STEP, 11'd255);
        release_cfg();
        repeat (6) send_pixel(make_pixel());
        wait_for_idle();

        // Geometry shrunk mid-frame: four pixels into a 6 x 3 frame the width drops to 2.
        // The next pixel sits past the new edge and closes its row at once, then two rows
        // of two finish the frame.
        write_reg(REG_FRAME_WIDTH, 11'd6);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        write_reg(REG_SAMPLE_STEP, 11'd1);
        release_cfg();
        repeat (4) send_pixel(make_pixel());
        wait_for_idle();
        write_reg(REG_FRAME_WIDTH, 11'd2);
        release_cfg();
        repeat (5) send_pixel(make_pixel());
        wait_for_idle();

        // Back pressure: tiny frames keep coming while the receiver holds off, so the
        // result register fills and the pixel input must stall until it drains.
        write_reg(REG_FRAME_WIDTH, 11'd2);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        release_cfg();
        hold_off_req <= 1'b1;
        repeat (30) send_frame();
        random_frames += 30;

        // Random settings and content. A few phases in the middle run with no gaps or
        // stalls on either side.
        phase = 0;
        while (random_pixels < RANDOM_PIXELS || random_frames < MIN_RANDOM_FRAMES) begin
            no_stall <= (phase >= 6 && phase < 10);
            random_phase();
            phase++;
        end

        wait_for_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/rgbcc_pkg.sv
rtl/core/rgb565_colour_class_counter_unit.sv
bench/rgbcc_checker.sv
bench/testbench.sv
